// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the process lifecycle table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Condition that must never be true outside reset.
`define ASSERT_NEVER_CLK(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER_CLK(label, clk, rst, cond)
`endif
`endif

// ===== rtl/plt_pkg.sv =====
// Types, constants and codes of the process lifecycle table.
package plt_pkg;

   // Table size and derived widths.
   localparam int TABLE_DEPTH = 128;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // Field widths of requests and responses.
   localparam int KIND_W    = 3;
   localparam int PID_W     = 32;
   localparam int CT_W      = 64;
   localparam int SEQ_W     = 32;
   localparam int IDX_OUT_W = 7;
   localparam int ACT_W     = 8;
   localparam int TOTAL_W   = 32;

   // One stored entry: active mark, creation time, pid.
   localparam int ENTRY_W = 1 + CT_W + PID_W;

   localparam logic [ACT_W-1:0] ACTIVE_MAX = '1;

   // Event kinds.
   localparam logic [KIND_W-1:0] KIND_START   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_STOP    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_NETWORK = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ALERT   = 3'd3;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT,
      ST_RESP
   } plt_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic step;
      logic commit;
   } plt_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;
   } plt_stat_type;

endpackage

// ===== rtl/plt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module plt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/plt_ctrl.sv =====
// Controller state machine of the process lifecycle table.
`include "assert_macros.svh"
module plt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  plt_pkg::plt_stat_type stat,
   output plt_pkg::plt_cmd_type  cmd
);
   import plt_pkg::*;

   plt_state_type state_ff;
   plt_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.scan_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_SCAN: begin
            cmd.step = 1'b1;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // Checks on sequencing.
   `ASSERT_NEVER_CLK(a_ready_and_valid, clock, reset, req_ready && rsp_valid)
   `ASSERT_CLK(a_commit_after_scan, clock, reset, cmd.commit |-> $past(stat.scan_done))
   `ASSERT_CLK(a_one_command, clock, reset, $onehot0({cmd.load, cmd.step, cmd.commit}))

endmodule

// ===== rtl/plt_datapath.sv =====
// Datapath of the process lifecycle table: entry memory, scan, update and counters.
`include "assert_macros.svh"
module plt_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  plt_pkg::plt_cmd_type           cmd,
   output plt_pkg::plt_stat_type          stat,
   input  logic [plt_pkg::KIND_W-1:0]     req_kind,
   input  logic [plt_pkg::PID_W-1:0]      req_pid,
   input  logic [plt_pkg::CT_W-1:0]       req_creation_time,
   output logic                           rsp_accepted,
   output logic                           rsp_status,
   output logic [plt_pkg::SEQ_W-1:0]      rsp_sequence_res,
   output logic [plt_pkg::IDX_OUT_W-1:0]  rsp_entry_index,
   output logic [plt_pkg::ACT_W-1:0]      rsp_active_total,
   output logic [plt_pkg::TOTAL_W-1:0]    rsp_network_total,
   output logic [plt_pkg::TOTAL_W-1:0]    rsp_alert_total
);
   import plt_pkg::*;

   // Request held for the whole event.
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [PID_W-1:0]   pid_ff, pid_in;
   logic [CT_W-1:0]    ct_ff, ct_in;

   // Scan control.
   logic [CNT_W-1:0]   left_ff, left_in;
   logic [IDX_W-1:0]   addr_ff, addr_in;
   logic               pend_ff, pend_in;
   logic [IDX_W-1:0]   pend_idx_ff, pend_idx_in;

   // Lookup result.
   logic               found_ff, found_in;
   logic               exact_ff, exact_in;
   logic [IDX_W-1:0]   found_idx_ff, found_idx_in;
   logic               found_act_ff, found_act_in;
   logic [CT_W-1:0]    found_ct_ff, found_ct_in;

   // Table state and counters.
   logic [CNT_W-1:0]   used_ff, used_in;
   logic [ACT_W-1:0]   active_ff, active_in;
   logic [TOTAL_W-1:0] network_ff, network_in;
   logic [TOTAL_W-1:0] alert_ff, alert_in;
   logic [SEQ_W-1:0]   next_ff, next_in;

   // Response registers.
   logic               acc_ff, acc_in;
   logic               status_ff, status_in;
   logic [SEQ_W-1:0]   seq_ff, seq_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;

   // Memory ports.
   logic               rd_en;
   logic [ENTRY_W-1:0] rd_data;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;

   // Compare of the entry read in the previous cycle.
   logic [PID_W-1:0]   rd_pid;
   logic [CT_W-1:0]    rd_ct;
   logic               rd_act;
   logic               cmp_match;
   logic               cmp_exact;
   logic               is_lifecycle;
   logic               is_start;
   logic [IDX_W+IDX_OUT_W-1:0] idx_wide;

   plt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   // Entry fields and match test.
   always_comb begin
      rd_pid    = rd_data[PID_W-1:0];
      rd_ct     = rd_data[PID_W +: CT_W];
      rd_act    = rd_data[ENTRY_W-1];
      rd_en     = cmd.step && (left_ff != '0) && !exact_ff;
      cmp_match = pend_ff && !exact_ff && (rd_pid == pid_ff) &&
                  ((rd_ct == ct_ff) || (rd_ct == '0) || (ct_ff == '0));
      cmp_exact = cmp_match && (rd_ct == ct_ff) && (ct_ff != '0);
      stat.scan_done = exact_ff || ((left_ff == '0) && !pend_ff);
   end

   // Request capture and newest-to-oldest scan.
   always_comb begin
      kind_in      = kind_ff;
      pid_in       = pid_ff;
      ct_in        = ct_ff;
      left_in      = left_ff;
      addr_in      = addr_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      found_in     = found_ff;
      exact_in     = exact_ff;
      found_idx_in = found_idx_ff;
      found_act_in = found_act_ff;
      found_ct_in  = found_ct_ff;
      if (cmd.load) begin
         kind_in  = req_kind;
         pid_in   = req_pid;
         ct_in    = req_creation_time;
         left_in  = (req_pid == '0) ? '0 : used_ff;
         addr_in  = IDX_W'(used_ff - CNT_W'(1));
         pend_in  = 1'b0;
         found_in = 1'b0;
         exact_in = 1'b0;
      end else if (cmd.step) begin
         pend_in     = rd_en;
         pend_idx_in = addr_ff;
         if (rd_en) begin
            addr_in = addr_ff - IDX_W'(1);
            left_in = left_ff - CNT_W'(1);
         end
         // An exact creation-time hit wins over any newer active match.
         if (cmp_exact || (cmp_match && rd_act && !found_ff)) begin
            found_in     = 1'b1;
            exact_in     = cmp_exact;
            found_idx_in = pend_idx_ff;
            found_act_in = rd_act;
            found_ct_in  = rd_ct;
         end
      end
   end

   // Event outcome: table update, counters and response.
   always_comb begin
      is_lifecycle = (kind_ff == KIND_START) || (kind_ff == KIND_STOP);
      is_start     = (kind_ff == KIND_START);
      used_in      = used_ff;
      active_in    = active_ff;
      network_in   = network_ff;
      alert_in     = alert_ff;
      next_in      = next_ff;
      acc_in       = acc_ff;
      status_in    = status_ff;
      seq_in       = seq_ff;
      idx_in       = idx_ff;
      wr_en        = 1'b0;
      wr_addr      = found_idx_ff;
      wr_data      = {found_act_ff, ((ct_ff != '0) ? ct_ff : found_ct_ff), pid_ff};
      if (cmd.commit) begin
         acc_in    = 1'b1;
         status_in = 1'b0;
         idx_in    = '0;
         if (is_lifecycle) begin
            if (found_ff) begin
               idx_in = found_idx_ff;
               if (is_start) begin
                  // Refresh only; the event is not numbered.
                  wr_en  = (ct_ff != '0);
                  acc_in = 1'b0;
               end else if (!found_act_ff) begin
                  acc_in = 1'b0;
               end else begin
                  wr_en   = 1'b1;
                  wr_data = {1'b0, ((ct_ff != '0) ? ct_ff : found_ct_ff), pid_ff};
                  if (active_ff != '0) begin
                     active_in = active_ff - ACT_W'(1);
                  end
               end
            end else if (used_ff < CNT_W'(TABLE_DEPTH)) begin
               // Append a new entry at the end of the table.
               wr_en   = 1'b1;
               wr_addr = IDX_W'(used_ff);
               wr_data = {is_start, ct_ff, pid_ff};
               idx_in  = IDX_W'(used_ff);
               used_in = used_ff + CNT_W'(1);
               if (is_start && (active_ff != ACTIVE_MAX)) begin
                  active_in = active_ff + ACT_W'(1);
               end
            end else begin
               acc_in    = 1'b0;
               status_in = 1'b1;
            end
         end else if (kind_ff == KIND_NETWORK) begin
            network_in = network_ff + TOTAL_W'(1);
         end else if (kind_ff == KIND_ALERT) begin
            alert_in = alert_ff + TOTAL_W'(1);
         end
         seq_in = acc_in ? next_ff : '0;
         if (acc_in) begin
            next_in = next_ff + SEQ_W'(1);
         end
      end
   end

   // Control and counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff    <= '0;
         pend_ff    <= 1'b0;
         found_ff   <= 1'b0;
         exact_ff   <= 1'b0;
         used_ff    <= '0;
         active_ff  <= '0;
         network_ff <= '0;
         alert_ff   <= '0;
         next_ff    <= SEQ_W'(1);
      end else begin
         left_ff    <= left_in;
         pend_ff    <= pend_in;
         found_ff   <= found_in;
         exact_ff   <= exact_in;
         used_ff    <= used_in;
         active_ff  <= active_in;
         network_ff <= network_in;
         alert_ff   <= alert_in;
         next_ff    <= next_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      pid_ff       <= pid_in;
      ct_ff        <= ct_in;
      addr_ff      <= addr_in;
      pend_idx_ff  <= pend_idx_in;
      found_idx_ff <= found_idx_in;
      found_act_ff <= found_act_in;
      found_ct_ff  <= found_ct_in;
      acc_ff       <= acc_in;
      status_ff    <= status_in;
      seq_ff       <= seq_in;
      idx_ff       <= idx_in;
   end

   // Response fields; the index is reported in its low bits.
   assign idx_wide          = {{IDX_OUT_W{1'b0}}, idx_ff};
   assign rsp_accepted      = acc_ff;
   assign rsp_status        = status_ff;
   assign rsp_sequence_res  = seq_ff;
   assign rsp_entry_index   = idx_wide[IDX_OUT_W-1:0];
   assign rsp_active_total  = active_ff;
   assign rsp_network_total = network_ff;
   assign rsp_alert_total   = alert_ff;

   // Checks on the table bookkeeping.
   `ASSERT_NEVER_CLK(a_used_bound, clock, reset, used_ff > CNT_W'(TABLE_DEPTH))
   `ASSERT_CLK(a_exact_is_found, clock, reset, exact_ff |-> found_ff)
   `ASSERT_CLK(a_number_on_commit, clock, reset, !cmd.commit |=> $stable(next_ff))

endmodule

// ===== rtl/process_lifecycle_table_top.sv =====
// Top level of the process lifecycle table.
// The scan does one memory read per cycle over the used entries, newest first. Pid zero or
// an empty table skips the scan, and an exact creation-time hit ends it early. The block
// takes one request at a time; a new one is accepted only after the response is taken.
// Reset clears the counts and sets the next sequence number to one.
module process_lifecycle_table_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [plt_pkg::KIND_W-1:0]     req_kind,
   input  logic [plt_pkg::PID_W-1:0]      req_pid,
   input  logic [plt_pkg::CT_W-1:0]       req_creation_time,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_accepted,
   output logic                           rsp_status,
   output logic [plt_pkg::SEQ_W-1:0]      rsp_sequence_res,
   output logic [plt_pkg::IDX_OUT_W-1:0]  rsp_entry_index,
   output logic [plt_pkg::ACT_W-1:0]      rsp_active_total,
   output logic [plt_pkg::TOTAL_W-1:0]    rsp_network_total,
   output logic [plt_pkg::TOTAL_W-1:0]    rsp_alert_total
);
   import plt_pkg::*;

   plt_cmd_type  cmd;
   plt_stat_type stat;

   // Sequencer.
   plt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Table, scan and counters.
   plt_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_kind          (req_kind),
      .req_pid           (req_pid),
      .req_creation_time (req_creation_time),
      .rsp_accepted      (rsp_accepted),
      .rsp_status        (rsp_status),
      .rsp_sequence_res  (rsp_sequence_res),
      .rsp_entry_index   (rsp_entry_index),
      .rsp_active_total  (rsp_active_total),
      .rsp_network_total (rsp_network_total),
      .rsp_alert_total   (rsp_alert_total)
   );

endmodule
